// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the raster delta transform.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define RDT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Property checked on every rising edge, also during reset.
`define RDT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rdt_pkg.sv =====
// Package for the raster delta transform: widths, register indexes, reset values
// and the line store write port type. No dependencies.
`default_nettype none

package rdt_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int DATA_W      = 16;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        MODE_FORWARD = 1'b0,
        MODE_INVERSE = 1'b1
    } mode_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ls_wr_t;

endpackage

`default_nettype wire

// ===== rtl/rdt_line_store.sv =====
// Line store for the raster delta transform: one row of 16-bit pixels,
// one write and one registered read per cycle. Depends on rdt_pkg.
`default_nettype none

module rdt_line_store (
    input  wire logic                  aclk,
    input  wire logic                  rd_en,
    input  wire logic [rdt_pkg::ADDR_W-1:0] rd_addr,
    output logic [rdt_pkg::DATA_W-1:0] rd_data,
    input  wire rdt_pkg::ls_wr_t       wr
);
    import rdt_pkg::*;

    logic [DATA_W-1:0] mem [MAX_WIDTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/raster_delta_transform.sv =====
// Raster delta transform top level: counters, predictor stage, output register.
// Depends on rdt_pkg, rdt_line_store and assert_macros.svh.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+-------------------------
//  s_      | s_valid s_ready s_in_value              | sample in, raster order
//  m_      | m_valid m_ready m_out_value m_last_of_frame | residual or pixel out
//  cfg_    | cfg_we cfg_index cfg_data               | register writes
//
// One item per cycle sustained while m_ready stays high; an accepted item is
// registered in the predictor stage, then in the output register driving m_valid.
// The accepting edge registers the line store read at the current column; the
// predictor stage forms the prediction and, as the item advances, writes the
// pixel back and loads the output register. A write-back to the column read at
// the same edge is forwarded. s_ready falls only while the output register is
// full and not taken. Reset is synchronous; the line store needs no clearing.
`default_nettype none

module raster_delta_transform (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rdt_pkg::DATA_W-1:0]  s_in_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [rdt_pkg::DATA_W-1:0]       m_out_value,
    output logic                             m_last_of_frame,
    input  wire logic                        cfg_we,
    input  wire logic [rdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rdt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rdt_pkg::*;
    `include "assert_macros.svh"

    // configuration
    mode_t               mode_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                cfg_hit;

    // raster position of the next item
    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                col_end, row_end, last_c;

    // predictor stage
    logic                p1_valid_reg;
    logic [DATA_W-1:0]   p1_value_reg;
    logic [ADDR_W-1:0]   p1_col_reg;
    logic                p1_first_row_reg;
    logic                p1_first_col_reg;
    logic                p1_last_reg;
    logic                fwd_reg;
    logic [DATA_W-1:0]   fwd_data_reg;
    logic [DATA_W-1:0]   left_reg;
    logic [DATA_W-1:0]   rd_data;
    logic [DATA_W-1:0]   above, pred, pixel_c, result_c;
    logic                p1_adv, s_acc;
    ls_wr_t              ls_wr;

    // output register
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_value_reg;
    logic                out_last_reg;

    always_comb begin
        cfg_hit = cfg_we && (cfg_index == CFG_MODE || cfg_index == CFG_WIDTH
                             || cfg_index == CFG_HEIGHT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_FORWARD;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_data[0]);
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (width_reg > WIDTH_MAX) begin
            eff_w = WIDTH_MAX;
        end else begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign p1_adv  = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        col_end  = ({1'b0, col_reg} == eff_w - WIDTH_W'(1));
        row_end  = (row_reg == eff_h - HEIGHT_W'(1));
        last_c   = col_end && row_end;
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + HEIGHT_W'(1);
            end else begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_value_reg     <= s_in_value;
            p1_col_reg       <= col_reg;
            p1_first_row_reg <= (row_reg == '0);
            p1_first_col_reg <= (col_reg == '0);
            p1_last_reg      <= last_c;
            fwd_reg          <= p1_adv && (p1_col_reg == col_reg);
            fwd_data_reg     <= pixel_c;
        end
    end

    rdt_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr      (ls_wr)
    );

    always_comb begin
        above = fwd_reg ? fwd_data_reg : rd_data;
        if (p1_first_row_reg) begin
            pred = p1_first_col_reg ? '0 : left_reg;
        end else begin
            pred = above;
        end
        if (mode_reg == MODE_INVERSE) begin
            pixel_c  = p1_value_reg + pred;
            result_c = pixel_c;
        end else begin
            pixel_c  = p1_value_reg;
            result_c = p1_value_reg - pred;
        end
        ls_wr.en   = p1_adv;
        ls_wr.addr = p1_col_reg;
        ls_wr.data = pixel_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (p1_adv) begin
            left_reg <= pixel_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            out_value_reg <= result_c;
            out_last_reg  <= p1_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_value     = out_value_reg;
    assign m_last_of_frame = out_last_reg;

    `RDT_ASSERT(a_col_in_row, aclk, aresetn, {1'b0, col_reg} < eff_w, "column beyond row width")
    `RDT_ASSERT(a_row_in_frame, aclk, aresetn, row_reg < eff_h, "row beyond frame height")
    `RDT_ASSERT(a_wrap_on_last, aclk, aresetn, s_acc && last_c |=> col_reg == '0 && row_reg == '0, "no wrap after last item")
    `RDT_ASSERT(a_fwd_same_col, aclk, aresetn, s_acc && fwd_reg == 1'b0 && p1_adv && p1_col_reg == col_reg |=> fwd_reg, "missed forwarding")
    `RDT_ASSERT_ALWAYS(a_stall_keeps_p1, aclk, p1_valid_reg && !p1_adv && aresetn |=> p1_valid_reg || !aresetn, "stalled item lost")

endmodule

`default_nettype wire

// ===== tb/sv/raster_delta_transform_test.sv =====
// Self-checking testbench for raster_delta_transform: predicts every output sample
// and compares it with the block's result stream. Depends on rdt_pkg and the RTL.
// Sender and receiver both idle at random.
module raster_delta_transform_test;
    import rdt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } sample_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_in_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DATA_W-1:0]     m_out_value;
    logic                  m_last_of_frame;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    mode_t               cur_mode;
    logic [WIDTH_W-1:0]  cur_width;
    logic [HEIGHT_W-1:0] cur_height;
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [DATA_W-1:0]   left_pixel;
    logic [DATA_W-1:0]   row_above [MAX_WIDTH];

    sample_result_t predicted_samples [$];
    sample_result_t head;
    bit             idling = 1'b1;
    int unsigned    stall_left = 0;
    int unsigned    ready_gap = 0;
    int unsigned    cycles = 0;
    int unsigned    mismatches = 0;
    int unsigned    samples_sent = 0;
    int unsigned    samples_checked = 0;
    int unsigned    reg_writes = 0;

    raster_delta_transform dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_value      (s_in_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_value     (m_out_value),
        .m_last_of_frame (m_last_of_frame),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d samples still outstanding", $time,
                     predicted_samples.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned frame_width();
        if (cur_width == 0) return 1;
        if (cur_width > MAX_WIDTH) return MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned frame_height();
        return (cur_height == 0) ? 1 : cur_height;
    endfunction

    function automatic sample_result_t predict_sample(input logic [DATA_W-1:0] v);
        int unsigned       w;
        int unsigned       h;
        logic [DATA_W-1:0] pixel;
        sample_result_t    r;
        w = frame_width();
        h = frame_height();
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        if (cur_mode == MODE_FORWARD) begin
            if (row_pos == 0)
                r.value = (col_pos == 0) ? v : v - left_pixel;
            else
                r.value = v - row_above[col_pos];
            pixel = v;
        end else begin
            if (row_pos == 0)
                pixel = (col_pos == 0) ? v : left_pixel + v;
            else
                pixel = row_above[col_pos] + v;
            r.value = pixel;
        end
        row_above[col_pos] = pixel;
        left_pixel = pixel;
        r.last = (col_pos == w - 1) && (row_pos == h - 1);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return r;
    endfunction

    // result side: random stalls, one draw per item
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            samples_checked++;
            if (predicted_samples.size() == 0) begin
                $display("%0t: unexpected item, expected none, got value %h last %b",
                         $time, m_out_value, m_last_of_frame);
                mismatches++;
            end else begin
                head = predicted_samples.pop_front();
                if (m_out_value !== head.value) begin
                    $display("%0t: out_value expected %h, got %h", $time, head.value,
                             m_out_value);
                    mismatches++;
                end
                if (m_last_of_frame !== head.last) begin
                    $display("%0t: last_of_frame expected %b, got %b", $time, head.last,
                             m_last_of_frame);
                    mismatches++;
                end
            end
            ready_gap = idling ? $urandom_range(0, 15) : 0;
            stall_left <= ready_gap;
            m_ready <= (ready_gap == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_MODE:   cur_mode = mode_t'(data[0]);
            CFG_WIDTH:  cur_width = data[WIDTH_W-1:0];
            CFG_HEIGHT: cur_height = data[HEIGHT_W-1:0];
            default: ;
        endcase
        if (idx != CFG_UNUSED) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] v);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_value <= v;
        predicted_samples.push_back(predict_sample(v));
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (predicted_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        // 640 wide by default: run into row 1 to check the wrap
        repeat (644) send_sample(16'($urandom));
        wait_idle();
    endtask

    task automatic test_small_frames();
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd2);
        for (int m = 0; m < 2; m++) begin
            write_reg(CFG_MODE, CFG_DATA_W'(m ? MODE_INVERSE : MODE_FORWARD));
            send_sample(16'hFFFF);
            send_sample(16'h0000);
            send_sample(16'hFFFF);
            send_sample(16'h0001);
            send_sample(16'hFFFF);
            send_sample(16'h8000);
            send_sample(16'h7FFF);
            send_sample(16'h0000);
            wait_idle();
        end
    endtask

    task automatic test_degenerate_sizes();
        // zero width and height act as one
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd0);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FORWARD));
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h0000);
        wait_idle();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_INVERSE));
        send_sample(16'h8001);
        send_sample(16'hFFFF);
        wait_idle();
        // single column, tallest frame
        write_reg(CFG_WIDTH, 16'd1);
        write_reg(CFG_HEIGHT, 16'hFFFF);
        repeat (5) send_sample(16'($urandom));
        send_sample(16'hFFFF);
        wait_idle();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FORWARD));
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        repeat (3) send_sample(16'($urandom));
        wait_idle();
    endtask

    task automatic test_frame_restart();
        write_reg(CFG_WIDTH, 16'd4);
        write_reg(CFG_HEIGHT, 16'd3);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FORWARD));
        repeat (6) send_sample(16'($urandom));
        wait_idle();
        // unknown index: frame position must survive
        write_reg(CFG_UNUSED, 16'hFFFF);
        repeat (9) send_sample(16'($urandom));
        wait_idle();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FORWARD));
        repeat (5) send_sample(16'($urandom));
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) write_reg(CFG_MODE, 16'($urandom));
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 15);
                w = (pick == 0) ? 0 : (pick < 12) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 40);
                write_reg(CFG_WIDTH, {3'($urandom), 13'(w)});
            end
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 15);
                case (pick)
                    0:       h = 0;
                    1:       h = 65535;
                    2:       h = $urandom_range(13, 65535);
                    3, 4:    h = $urandom_range(6, 12);
                    default: h = $urandom_range(1, 5);
                endcase
                write_reg(CFG_HEIGHT, 16'(h));
            end
            if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom));
            w = frame_width();
            h = frame_height();
            if ($urandom_range(0, 3) != 0 && w * h <= 64)
                n = w * h * $urandom_range(1, 3);
            else
                n = $urandom_range(1, 48);
            idling = ($urandom_range(0, 3) != 0);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0:       send_sample(16'h0000);
                    1:       send_sample(16'hFFFF);
                    default: send_sample(16'($urandom));
                endcase
            end
            sent += n;
            wait_idle();
        end
        idling = 1'b1;
    endtask

    initial begin
        cur_mode = MODE_FORWARD;
        cur_width = WIDTH_RESET;
        cur_height = HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        left_pixel = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_small_frames();
        test_degenerate_sizes();
        test_frame_restart();
        test_random_frames();
        wait_idle();

        $display("%0d samples sent, %0d results checked, %0d register writes",
                 samples_sent, samples_checked, reg_writes);
        $display("both modes, widths 0 to 40 and 640, heights 0 to 65535, restarts mid-frame");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
